// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ACM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ACM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/acm_pkg.sv =====
package acm_pkg;

  localparam int STORE_DEPTH  = 32;
  localparam int CHANNEL_CAP  = 100;
  localparam int ANODE_CAP    = 80;
  localparam int ANODE_GROUPS = 10;
  localparam int MAX_RESULTS  = 33;
  localparam int NCHANNELS    = 40;
  localparam int NANODES      = 10;

  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int IDX_W  = $clog2(NCHANNELS);
  localparam int EMIT_W = $clog2(MAX_RESULTS);
  localparam int KID_W  = $clog2(NANODES);

  // config port
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 21;
  localparam logic [CFG_IW-1:0] CFG_THR   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_WIN   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_OFF   = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_LIM   = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_EARLY = 3'd4;

  localparam logic [14:0]        THR_RST   = 15'd0;
  localparam logic [19:0]        WIN_RST   = 20'd2000;
  localparam logic signed [15:0] OFF_RST   = 16'sd120;
  localparam logic [6:0]         LIM_RST   = 7'd63;
  localparam logic signed [20:0] EARLY_RST = -21'sd7200;

  // opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_ANODE = 2'd2;

  // result kinds
  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic [6:0]  chan;
    logic [31:0] tval;
    logic [15:0] amp;
  } entry_t;

  typedef struct packed {
    logic [6:0]       base_chan;
    logic [IDX_W-1:0] base_idx;
    logic             grp_ok;
    logic [31:0]      t;
    logic [32:0]      hi;
  } anode_t;

  typedef struct packed {
    logic adv;
    logic slot_vld;
    logic clr_bunch;
    logic new_hit;
  } mctl_t;

  typedef struct packed {
    logic   vld;
    entry_t ent;
  } mres_t;

  // channel 1..99 with ones digit 1..4
  function automatic logic chan_ok(input logic [6:0] ch);
    logic ok;
    ok = 1'b0;
    for (int k = 0; k < 10; k++) begin
      if (ch >= 7'(10 * k + 1) && ch <= 7'(10 * k + 4)) begin
        ok = 1'b1;
      end
    end
    return ok;
  endfunction

endpackage

// ===== rtl/core/acm_cell.sv =====
module acm_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  acm_pkg::entry_t d,
  output acm_pkg::entry_t q
);
  import acm_pkg::*;

  entry_t ent_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      ent_r <= d;
    end
  end

  assign q = ent_r;

endmodule

// ===== rtl/core/acm_chain.sv =====
module acm_chain (
  input  logic            clk,
  input  logic            shift_en,
  input  logic            load,
  input  acm_pkg::entry_t load_ent,
  output acm_pkg::entry_t head
);
  import acm_pkg::*;

  entry_t q [STORE_DEPTH];
  entry_t tail_in;

  // new words enter at the tail; otherwise the head wraps around
  assign tail_in = load ? load_ent : q[0];

  for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_cell
    if (k == STORE_DEPTH - 1) begin : g_tail
      acm_cell u_cell (.clk(clk), .shift_en(shift_en), .d(tail_in), .q(q[k]));
    end else begin : g_mid
      acm_cell u_cell (.clk(clk), .shift_en(shift_en), .d(q[k+1]), .q(q[k]));
    end
  end

  assign head = q[0];

endmodule

// ===== rtl/core/acm_match.sv =====
module acm_match (
  input  logic            clk,
  input  logic            rst_n,
  input  acm_pkg::mctl_t  ctl,
  input  acm_pkg::anode_t anode,
  input  acm_pkg::entry_t head,
  output acm_pkg::mres_t  res,
  output logic            matched
);
  import acm_pkg::*;

  logic                   in_grp;
  logic                   in_win;
  logic                   hit_a;
  logic [IDX_W-1:0]       idx_a;
  logic signed [32:0]     ht;
  logic signed [32:0]     at;
  logic signed [32:0]     hi;

  logic                   b_vld_r;
  logic [IDX_W-1:0]       b_idx_r;
  entry_t                 b_ent_r;
  logic [6:0]             rd_cnt_r;
  logic                   rd_vld_r;
  logic                   fwd_vld_r;
  logic [IDX_W-1:0]       fwd_idx_r;
  logic [6:0]             fwd_cnt_r;
  logic                   matched_r;
  logic [EMIT_W-1:0]      emit_cnt_r;

  logic [6:0]             cnt_mem [NCHANNELS];
  logic [NCHANNELS-1:0]   cnt_vld_r;

  logic [6:0]             cur;
  logic                   wr;
  logic                   emit;

  // stage A: test the head cell against the anode group and window
  assign ht = $signed({head.tval[31], head.tval});
  assign at = $signed({anode.t[31], anode.t});
  assign hi = $signed(anode.hi);

  assign in_grp = anode.grp_ok && head.chan >= anode.base_chan + 7'd1 &&
                  head.chan <= anode.base_chan + 7'd4;
  assign in_win = ht >= at && ht <= hi;
  assign hit_a  = ctl.slot_vld && in_grp && in_win;
  assign idx_a  = anode.base_idx + IDX_W'(head.chan - anode.base_chan - 7'd1);

  // stage B: per-channel count, with bypass of last cycle's write
  assign cur  = (fwd_vld_r && fwd_idx_r == b_idx_r) ? fwd_cnt_r :
                (rd_vld_r ? rd_cnt_r : 7'd0);
  assign wr   = b_vld_r && cur < 7'(CHANNEL_CAP);
  assign emit = wr && emit_cnt_r < EMIT_W'(MAX_RESULTS - 1);

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      if (wr) begin
        cnt_mem[b_idx_r] <= cur + 7'd1;
      end
      rd_cnt_r <= cnt_mem[idx_a];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      b_idx_r   <= idx_a;
      b_ent_r   <= head;
      rd_vld_r  <= cnt_vld_r[idx_a];
      fwd_idx_r <= b_idx_r;
      fwd_cnt_r <= cur + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r  <= '0;
      fwd_vld_r  <= 1'b0;
      b_vld_r    <= 1'b0;
      matched_r  <= 1'b0;
      emit_cnt_r <= '0;
    end else begin
      if (ctl.clr_bunch) begin
        cnt_vld_r <= '0;
        fwd_vld_r <= 1'b0;
      end else if (ctl.adv) begin
        if (wr) begin
          cnt_vld_r[b_idx_r] <= 1'b1;
        end
        fwd_vld_r <= wr;
      end
      if (ctl.new_hit) begin
        b_vld_r    <= 1'b0;
        matched_r  <= 1'b0;
        emit_cnt_r <= '0;
      end else if (ctl.adv) begin
        b_vld_r <= hit_a;
        if (hit_a) begin
          matched_r <= 1'b1;
        end
        if (emit) begin
          emit_cnt_r <= emit_cnt_r + EMIT_W'(1);
        end
      end
    end
  end

  assign res.vld = emit;
  assign res.ent = b_ent_r;
  assign matched = matched_r;

endmodule

// ===== rtl/core/anode_cathode_coincidence_matcher.sv =====
// Channel   Direction  Handshake              Words
// in_       input      in_valid / in_ready    start bunch, cathode load, anode hit
// out_      output     out_valid / out_ready  matched cathodes, then one verdict
// cfg_      input      cfg_valid / cfg_ready  register writes, index + data
//
// Start and load words are accepted back to back while no anode hit is in progress.
// An anode hit runs from accept to its verdict in the output register as follows:
// the cathode chain rotates one cell per cycle, unless out_ready stalls, past a
// single compare head, plus one stage for the channel-count memory read and one for the verdict.
// A stalled out_ready freezes the scan of the chain and the match pipeline in place.
// rst_n (synchronous) empties the store, clears counters and overflow, loads
// the register defaults. Config is always ready.
module anode_cathode_coincidence_matcher (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_op,
  input  logic [6:0]                    in_detector_number,
  input  logic signed [31:0]            in_hit_time,
  input  logic signed [15:0]            in_amplitude,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kind,
  output logic [6:0]                    out_channel,
  output logic signed [31:0]            out_time_value,
  output logic signed [15:0]            out_amplitude_value,
  output logic                          out_anode_kept,
  output logic                          out_store_overflowed,
  output logic                          out_last,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [acm_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [acm_pkg::CFG_DW-1:0]    cfg_data
);
  import acm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_VERD  = 2'd3;

  // config registers
  logic [14:0]        thr_r;
  logic [19:0]        win_r;
  logic signed [15:0] off_r;
  logic [6:0]         lim_r;
  logic signed [20:0] early_r;

  // bunch state
  logic [CNT_W-1:0]   count_r;
  logic [31:0]        ref_r;
  logic               ovf_r;
  logic [6:0]         kept_cnt_r [NANODES];

  // anode hit in progress
  logic [1:0]         state_r;
  logic [1:0]         state_nxt;
  logic [CNT_W-1:0]   step_r;
  anode_t             anode_r;
  logic [6:0]         an_det_r;
  logic [15:0]        an_amp_r;

  // output register
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               out_kind_r;
  logic [6:0]         out_chan_r;
  logic [31:0]        out_time_r;
  logic [15:0]        out_amp_r;
  logic               out_kept_r;
  logic               out_ovf_r;
  logic               out_last_r;

  logic               accept;
  logic               adv;
  logic               busy;

  // cathode correction
  logic signed [32:0] diff;
  logic signed [33:0] ct_wide;
  logic [31:0]        ct_sat;
  logic [15:0]        mag;
  logic               pass;
  logic               do_load;
  logic               do_ovf;
  entry_t             load_ent;

  // anode setup
  anode_t             anode_new;
  logic               slot_vld;
  logic               scan_last;
  logic [KID_W-1:0]   kid;
  logic               kept;

  entry_t             head;
  mctl_t              mctl;
  mres_t              mres;
  logic               matched;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign adv       = !out_valid_r || out_ready;
  assign busy      = (state_r != ST_IDLE);

  // corrected time, computed exactly then saturated to 32 bits
  assign diff    = $signed({in_hit_time[31], in_hit_time}) - $signed({ref_r[31], ref_r});
  assign ct_wide = $signed({diff[32], diff}) +
                   ((in_detector_number < lim_r) ?
                    $signed({{18{off_r[15]}}, off_r}) : 34'sd0);

  always_comb begin
    if (ct_wide[33:31] == 3'b000 || ct_wide[33:31] == 3'b111) begin
      ct_sat = ct_wide[31:0];
    end else if (ct_wide[33]) begin
      ct_sat = 32'h8000_0000;
    end else begin
      ct_sat = 32'h7FFF_FFFF;
    end
  end

  assign mag  = in_amplitude[15] ? (~in_amplitude + 16'd1) : in_amplitude;
  assign pass = (mag > {1'b0, thr_r}) &&
                ($signed(ct_sat) > $signed({{11{early_r[20]}}, early_r})) &&
                chan_ok(in_detector_number);

  assign do_load = accept && in_op == OP_LOAD && pass && count_r < CNT_W'(STORE_DEPTH);
  assign do_ovf  = accept && in_op == OP_LOAD && pass && count_r >= CNT_W'(STORE_DEPTH);

  assign load_ent.chan = in_detector_number;
  assign load_ent.tval = ct_sat;
  assign load_ent.amp  = in_amplitude;

  // anode group: channels 10*a+1 .. 10*a+4, count index 4*a .. 4*a+3
  assign anode_new.grp_ok    = in_detector_number < 7'(ANODE_GROUPS);
  assign anode_new.base_chan = 7'({in_detector_number, 3'b000} + {3'b000, in_detector_number, 1'b0});
  assign anode_new.base_idx  = IDX_W'({in_detector_number, 2'b00});
  assign anode_new.t         = in_hit_time;
  assign anode_new.hi        = $signed({in_hit_time[31], in_hit_time}) + $signed({13'd0, win_r});

  // chain holds the newest count_r words at its tail end; a scan rotates it
  // a full turn, so head slots before that region are empty
  assign slot_vld  = (state_r == ST_SCAN) &&
                     ({1'b0, step_r} + {1'b0, count_r} >= (CNT_W+1)'(STORE_DEPTH));
  assign scan_last = (step_r == CNT_W'(STORE_DEPTH - 1));

  assign kid  = anode_r.grp_ok ? an_det_r[KID_W-1:0] : '0;
  assign kept = anode_r.grp_ok && matched && kept_cnt_r[kid] < 7'(ANODE_CAP);

  assign mctl.adv       = adv && busy;
  assign mctl.slot_vld  = slot_vld;
  assign mctl.clr_bunch = accept && in_op == OP_START;
  assign mctl.new_hit   = accept && in_op == OP_ANODE;

  acm_chain u_chain (
    .clk      (clk),
    .shift_en (do_load || (state_r == ST_SCAN && adv)),
    .load     (do_load),
    .load_ent (load_ent),
    .head     (head)
  );

  acm_match u_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mctl),
    .anode   (anode_r),
    .head    (head),
    .res     (mres),
    .matched (matched)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_op == OP_ANODE) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (adv && scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (adv) begin
          state_nxt = ST_VERD;
        end
      end
      ST_VERD: begin
        if (adv) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      case (state_r)
        ST_SCAN, ST_DRAIN: out_valid_nxt = mres.vld;
        ST_VERD:           out_valid_nxt = 1'b1;
        default:           out_valid_nxt = 1'b0;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THR_RST;
      win_r       <= WIN_RST;
      off_r       <= OFF_RST;
      lim_r       <= LIM_RST;
      early_r     <= EARLY_RST;
      count_r     <= '0;
      ref_r       <= '0;
      ovf_r       <= 1'b0;
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NANODES; i++) begin
        kept_cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THR:   thr_r   <= cfg_data[14:0];
          CFG_WIN:   win_r   <= cfg_data[19:0];
          CFG_OFF:   off_r   <= cfg_data[15:0];
          CFG_LIM:   lim_r   <= cfg_data[6:0];
          CFG_EARLY: early_r <= cfg_data[20:0];
          default: ;
        endcase
      end

      if (accept && in_op == OP_START) begin
        count_r <= '0;
        ref_r   <= in_hit_time;
        ovf_r   <= 1'b0;
        for (int i = 0; i < NANODES; i++) begin
          kept_cnt_r[i] <= '0;
        end
      end
      if (do_load) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (do_ovf) begin
        ovf_r <= 1'b1;
      end

      if (accept && in_op == OP_ANODE) begin
        step_r <= '0;
      end else if (state_r == ST_SCAN && adv) begin
        step_r <= step_r + CNT_W'(1);
      end

      if (state_r == ST_VERD && adv && kept) begin
        kept_cnt_r[kid] <= kept_cnt_r[kid] + 7'd1;
      end
    end
  end

  // payload; the overflow flag is captured with the word so that a start or
  // load taken while the verdict waits cannot change it
  always_ff @(posedge clk) begin
    if (accept && in_op == OP_ANODE) begin
      anode_r  <= anode_new;
      an_det_r <= in_detector_number;
      an_amp_r <= in_amplitude;
    end
    if (adv) begin
      out_ovf_r <= ovf_r;
      if (state_r == ST_VERD) begin
        out_kind_r <= KIND_VERDICT;
        out_chan_r <= an_det_r;
        out_time_r <= anode_r.t;
        out_amp_r  <= an_amp_r;
        out_kept_r <= kept;
        out_last_r <= 1'b1;
      end else begin
        out_kind_r <= KIND_MATCH;
        out_chan_r <= mres.ent.chan;
        out_time_r <= mres.ent.tval;
        out_amp_r  <= mres.ent.amp;
        out_kept_r <= 1'b0;
        out_last_r <= 1'b0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_kind             = out_kind_r;
  assign out_channel          = out_chan_r;
  assign out_time_value       = out_time_r;
  assign out_amplitude_value  = out_amp_r;
  assign out_anode_kept       = out_kept_r;
  assign out_store_overflowed = out_ovf_r;
  assign out_last             = out_last_r;

endmodule

// ===== rtl/core/acm_checker.sv =====
`include "assert_macros.svh"

module acm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [1:0]                 in_op,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_kind,
  input logic [6:0]                 out_channel,
  input logic signed [31:0]         out_time_value,
  input logic signed [15:0]         out_amplitude_value,
  input logic                       out_anode_kept,
  input logic                       out_store_overflowed,
  input logic                       out_last
);
  import acm_pkg::*;

  // a stalled result word holds
  `ACM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_time_value) && $stable(out_kind) && $stable(out_channel) && $stable(out_amplitude_value) && $stable(out_store_overflowed),
    "stalled result word changed")

  // only the verdict closes an anode hit
  `ACM_ASSERT_IMP(a_last_kind, clk, rst_n, out_valid, out_last == out_kind,
    "last flag does not match verdict kind")

  // matched cathode words never carry the keep bit
  `ACM_ASSERT_IMP(a_match_kept, clk, rst_n, out_valid && out_kind == KIND_MATCH,
    !out_anode_kept, "keep bit set on a matched cathode word")

  // an anode hit blocks the input until its verdict reaches the output register
  `ACM_ASSERT_NXT(a_scan_busy, clk, rst_n, in_valid && in_ready && in_op == OP_ANODE,
    !in_ready, "input ready right after an anode hit")

  // while a match word waits, the verdict is still to come
  `ACM_ASSERT_IMP(a_mid_hit, clk, rst_n, out_valid && !out_last, !in_ready,
    "input ready before the verdict")

endmodule

bind anode_cathode_coincidence_matcher acm_checker u_acm_checker (.*);
